FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define MNP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define MNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MNP_ASSERT(label, clk, rst, prop, msg)
`define MNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hdl/mnp_pkg.sv
// ----------------------------------------------------------------------------
// mnp_pkg
// Shared types and constants of the MIDI note pairing engine.
// ----------------------------------------------------------------------------
package mnp_pkg;

  localparam int         CHANNEL_COUNT  = 16;
  localparam logic [6:0] PAN_CONTROLLER = 7'd10;
  localparam logic [6:0] PAN_CENTER     = 7'd64;
  localparam logic [3:0] DRUM_CHANNEL   = 4'd9;

  // register index as decoded from paddr[2]
  localparam logic CFG_SKIPPED_IDX = 1'b0;

  typedef enum logic [2:0] {
    ACT_NOTE_ON     = 3'd0,
    ACT_NOTE_OFF    = 3'd1,
    ACT_PROGRAM     = 3'd2,
    ACT_CONTROL     = 3'd3,
    ACT_TRACK_START = 3'd4
  } action_t;

  typedef enum logic {
    KIND_NOTE = 1'b0,
    KIND_FULL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [31:0] tick_time;
  } event_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] begin_ticks;
    logic [31:0] end_ticks;
    logic [6:0]  program_number;
    logic [3:0]  note_channel;
    logic [6:0]  note_number;
    logic [6:0]  note_velocity;
    logic [6:0]  pan_value;
  } note_word_t;

  // one pending note-on, 50 bits
  typedef struct packed {
    logic [31:0] tick;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic [6:0]  vel;
  } pend_entry_t;

  typedef struct packed {
    logic more;   // another entry follows the current one
    logic match;  // current entry has the searched note and channel
  } scan_status_t;

endpackage

FILE: hdl/mnp_stream_if.sv
// ----------------------------------------------------------------------------
// mnp_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface mnp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/mnp_pend_table.sv
// ----------------------------------------------------------------------------
// mnp_pend_table
// Pending note-on store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mnp_pend_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  mnp_pkg::pend_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output mnp_pkg::pend_entry_t rd_data
);

  mnp_pkg::pend_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered from the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/mnp_scan_unit.sv
// ----------------------------------------------------------------------------
// mnp_scan_unit
// Shared step unit of the table walk: next index, bound check, key compare.
// ----------------------------------------------------------------------------
module mnp_scan_unit #(
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic [AW-1:0]         idx,
  input  logic [CW-1:0]         count,
  input  mnp_pkg::pend_entry_t  entry,
  input  logic [3:0]            key_chan,
  input  logic [6:0]            key_note,
  output logic [CW-1:0]         nxt,
  output mnp_pkg::scan_status_t status
);

  // step to the following entry
  assign nxt = CW'(idx) + CW'(1);

  // bound and key compare
  assign status.more  = (nxt < count);
  assign status.match = (entry.chan == key_chan) && (entry.note == key_note);

endmodule

FILE: hdl/midi_note_pairing_engine.sv
// Program, control, track-start and stored note-on words complete without leaving idle.
// Note-off walks the pending entries, one table entry per cycle, and gives a result
//   unless no entry matches or the channel is skipped; a full-table note-on gives one too.
// A result is registered; the next result waits until that note word drains.
// Reset (rst, synchronous): count zero, programs 0, pans 64, skipped channel 9;
//   table contents are not cleared, so there is no clearing pass.
// ----------------------------------------------------------------------------
// midi_note_pairing_engine
// Pairs MIDI note-on and note-off words into merged notes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_note_pairing_engine #(
  parameter int PENDING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  mnp_stream_if.sink          ev,
  mnp_stream_if.source        note,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int             AW      = $clog2(PENDING_DEPTH);
  localparam int             CW      = $clog2(PENDING_DEPTH + 1);
  localparam logic [CW-1:0]  DEPTH_C = CW'(PENDING_DEPTH);

  mnp_pkg::state_t       state, state_next;
  mnp_pkg::event_word_t  ev_q;
  mnp_pkg::pend_entry_t  hit;
  mnp_pkg::note_word_t   out_data, res_word;
  logic                  out_valid;
  logic [CW-1:0]         pend_count, pend_count_next;
  logic [AW-1:0]         idx, idx_next;
  logic [3:0]            skipped;
  logic [6:0]            prog_tab [mnp_pkg::CHANNEL_COUNT];
  logic [6:0]            pan_tab  [mnp_pkg::CHANNEL_COUNT];

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  mnp_pkg::pend_entry_t  wr_data, rd_data;
  logic [CW-1:0]         nxt;
  mnp_pkg::scan_status_t scan_st;

  logic ev_fire, out_free, out_load, hit_load, done_remove, cfg_write;

  assign ev_fire  = ev.valid && ev.ready;
  assign out_free = !out_valid || note.ready;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == mnp_pkg::CFG_SKIPPED_IDX);
  assign prdata    = (paddr[2] == mnp_pkg::CFG_SKIPPED_IDX) ? {28'd0, skipped} : 32'd0;

  // channels
  assign ev.ready   = (state == mnp_pkg::ST_IDLE);
  assign note.valid = out_valid;
  assign note.data  = out_data;

  mnp_pend_table #(
    .DEPTH (PENDING_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mnp_scan_unit #(
    .AW (AW),
    .CW (CW)
  ) u_scan (
    .idx      (idx),
    .count    (pend_count),
    .entry    (rd_data),
    .key_chan (ev_q.channel),
    .key_note (ev_q.first_data),
    .nxt      (nxt),
    .status   (scan_st)
  );

  // sequencer: next state, table ports
  always_comb begin
    state_next      = state;
    pend_count_next = pend_count;
    idx_next        = idx;
    wr_en           = 1'b0;
    wr_addr         = pend_count[AW-1:0];
    wr_data         = '{tick: ev.data.tick_time, chan: ev.data.channel,
                        note: ev.data.first_data, vel: ev.data.second_data};
    rd_en           = 1'b0;
    rd_addr         = nxt[AW-1:0];
    out_load        = 1'b0;
    hit_load        = 1'b0;
    done_remove     = 1'b0;
    case (state)
      mnp_pkg::ST_IDLE: begin
        if (ev_fire) begin
          case (ev.data.action)
            mnp_pkg::ACT_NOTE_ON: begin
              if (pend_count < DEPTH_C) begin
                wr_en           = 1'b1;
                pend_count_next = pend_count + CW'(1);
              end else begin
                state_next = mnp_pkg::ST_RESULT;
              end
            end
            mnp_pkg::ACT_NOTE_OFF: begin
              if (pend_count != '0) begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = mnp_pkg::ST_SEARCH;
              end
            end
            mnp_pkg::ACT_TRACK_START: begin
              pend_count_next = '0;
            end
            default: ;
          endcase
        end
      end
      mnp_pkg::ST_SEARCH: begin
        // rd_data holds entry idx; fetch the next one either way
        if (scan_st.more) begin
          rd_en    = 1'b1;
          idx_next = nxt[AW-1:0];
        end
        if (scan_st.match) begin
          hit_load = 1'b1;
          if (scan_st.more) begin
            state_next = mnp_pkg::ST_SHIFT;
          end else begin
            done_remove = 1'b1;
          end
        end else if (!scan_st.more) begin
          state_next = mnp_pkg::ST_IDLE;
        end
      end
      mnp_pkg::ST_SHIFT: begin
        // move entry idx down one place
        wr_en   = 1'b1;
        wr_addr = idx - AW'(1);
        wr_data = rd_data;
        if (scan_st.more) begin
          rd_en    = 1'b1;
          idx_next = nxt[AW-1:0];
        end else begin
          done_remove = 1'b1;
        end
      end
      mnp_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = mnp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mnp_pkg::ST_IDLE;
      end
    endcase
    // removal done: drop count, report unless skipped channel
    if (done_remove) begin
      pend_count_next = pend_count - CW'(1);
      state_next      = (ev_q.channel == skipped) ? mnp_pkg::ST_IDLE : mnp_pkg::ST_RESULT;
    end
  end

  // result word
  always_comb begin
    res_word = '0;
    if (ev_q.action == mnp_pkg::ACT_NOTE_ON) begin
      res_word.result_kind   = mnp_pkg::KIND_FULL;
      res_word.begin_ticks   = ev_q.tick_time;
      res_word.note_channel  = ev_q.channel;
      res_word.note_number   = ev_q.first_data;
      res_word.note_velocity = ev_q.second_data;
    end else begin
      res_word.result_kind    = mnp_pkg::KIND_NOTE;
      res_word.begin_ticks    = hit.tick;
      res_word.end_ticks      = (ev_q.tick_time == hit.tick) ? hit.tick + 32'd1
                                                             : ev_q.tick_time;
      res_word.program_number = prog_tab[ev_q.channel];
      res_word.note_channel   = ev_q.channel;
      res_word.note_number    = ev_q.first_data;
      res_word.note_velocity  = hit.vel;
      res_word.pan_value      = pan_tab[ev_q.channel];
    end
  end

  // control state and channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mnp_pkg::ST_IDLE;
      pend_count <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
      skipped    <= mnp_pkg::DRUM_CHANNEL;
      for (int c = 0; c < mnp_pkg::CHANNEL_COUNT; c++) begin
        prog_tab[c] <= '0;
        pan_tab[c]  <= mnp_pkg::PAN_CENTER;
      end
    end else begin
      state      <= state_next;
      pend_count <= pend_count_next;
      idx        <= idx_next;
      if (cfg_write) begin
        skipped <= pwdata[3:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (note.ready) begin
        out_valid <= 1'b0;
      end
      if (ev_fire) begin
        case (ev.data.action)
          mnp_pkg::ACT_PROGRAM: begin
            prog_tab[ev.data.channel] <= ev.data.first_data;
          end
          mnp_pkg::ACT_CONTROL: begin
            if (ev.data.first_data == mnp_pkg::PAN_CONTROLLER) begin
              pan_tab[ev.data.channel] <= ev.data.second_data;
            end
          end
          mnp_pkg::ACT_TRACK_START: begin
            for (int c = 0; c < mnp_pkg::CHANNEL_COUNT; c++) begin
              prog_tab[c] <= '0;
              pan_tab[c]  <= mnp_pkg::PAN_CENTER;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ev_fire) begin
      ev_q <= ev.data;
    end
    if (hit_load) begin
      hit <= rd_data;
    end
    if (out_load) begin
      out_data <= res_word;
    end
  end

  // checks
  `MNP_ASSERT(a_count_bound, clk, rst, pend_count <= DEPTH_C, "pending count above depth")
  `MNP_ASSERT_NEXT(a_remove_dec, clk, rst, done_remove, pend_count == $past(pend_count) - CW'(1), "removal did not drop count by one")
  `MNP_ASSERT_NEXT(a_insert_inc, clk, rst, ev_fire && ev.data.action == mnp_pkg::ACT_NOTE_ON && pend_count < DEPTH_C, pend_count == $past(pend_count) + CW'(1), "note-on did not raise count by one")
  `MNP_ASSERT(a_walk_bound, clk, rst, (state == mnp_pkg::ST_SEARCH || state == mnp_pkg::ST_SHIFT) |-> (CW'(idx) < pend_count), "table walk beyond pending entries")

endmodule
